// File: rtl/dhtr_pkg.sv
package dhtr_pkg;

   // field and state widths
   localparam int BYTE_W   = 8;
   localparam int RUN_W    = 8;
   localparam int IDX_W    = 7;
   localparam int CNT_W    = 6;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   // frame geometry
   localparam int FRAME_BITS     = 40;
   localparam int MAX_RUNS       = 85;
   localparam int FIRST_DATA_RUN = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 1'b1;

   // register reset values
   localparam logic [RUN_W-1:0] BIT_THRESHOLD_RST = 8'd16;
   localparam logic [RUN_W-1:0] TIMEOUT_TICKS_RST = 8'd255;

   // frame status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd2;

   // one finished capture as handed from front to back
   typedef struct packed {
      logic [FRAME_BITS-1:0] bits;
      logic [CNT_W-1:0]      count;
   } frame_type;

endpackage

// File: rtl/dhtr_if.sv
interface dhtr_req_if;
   import dhtr_pkg::*;
   logic valid;
   logic ready;
   logic start_req;
   logic pin_level;
   modport source (output valid, output start_req, output pin_level, input ready);
   modport sink (input valid, input start_req, input pin_level, output ready);
endinterface

interface dhtr_rsp_if;
   import dhtr_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   humidity_whole;
   logic [BYTE_W-1:0]   humidity_tenths;
   logic [BYTE_W-1:0]   temp_whole;
   logic [BYTE_W-1:0]   temp_tenths;
   logic [STATUS_W-1:0] frame_status;
   modport source (output valid, output humidity_whole, output humidity_tenths,
                   output temp_whole, output temp_tenths, output frame_status,
                   input ready);
   modport sink (input valid, input humidity_whole, input humidity_tenths,
                 input temp_whole, input temp_tenths, input frame_status,
                 output ready);
endinterface

interface dhtr_csr_if;
   import dhtr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [RUN_W-1:0]     wr_data;
   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/dhtr_front.sv
module dhtr_front (
   input  logic                       clock,
   input  logic                       reset,
   dhtr_req_if.sink                   req_bus,
   input  logic [dhtr_pkg::RUN_W-1:0] bit_threshold,
   input  logic [dhtr_pkg::RUN_W-1:0] timeout_ticks,
   input  logic                       queue_full,
   output logic                       push_valid,
   output dhtr_pkg::frame_type        push_data
);
   import dhtr_pkg::*;

   logic                  active_ff, active_in;
   logic                  prev_ff, prev_in;
   logic [RUN_W-1:0]      len_ff, len_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [FRAME_BITS-1:0] bits_ff, bits_in;
   logic                  accept;

   // a sample is taken whenever the queue has room for a possible frame
   assign req_bus.ready = ~queue_full;
   assign accept        = req_bus.valid & req_bus.ready;

   // run measurement and bit decode, one sample per transaction
   always_comb begin
      logic             take_bit;
      logic             max_hit;
      logic [IDX_W-1:0] idx_next;
      active_in  = active_ff;
      prev_in    = prev_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      bits_in    = bits_ff;
      push_valid = 1'b0;
      take_bit   = (idx_ff >= IDX_W'(FIRST_DATA_RUN)) && !idx_ff[0]
                   && (cnt_ff < CNT_W'(FRAME_BITS));
      idx_next   = idx_ff + 1'b1;
      max_hit    = 1'b0;
      if (accept) begin
         if (req_bus.start_req) begin
            active_in = 1'b1;
            prev_in   = 1'b1;
            len_in    = '0;
            idx_in    = '0;
            cnt_in    = '0;
            bits_in   = '0;
         end else if (active_ff) begin
            if (req_bus.pin_level == prev_ff) begin
               if (len_ff != {RUN_W{1'b1}}) begin
                  len_in = len_ff + 1'b1;
               end
            end else begin
               // end of a run: even runs from the first data run on are bits
               if (take_bit) begin
                  bits_in = {bits_ff[FRAME_BITS-2:0], (len_ff > bit_threshold)};
                  cnt_in  = cnt_ff + 1'b1;
               end
               idx_in  = idx_next;
               prev_in = req_bus.pin_level;
               max_hit = (idx_next >= IDX_W'(MAX_RUNS));
               if (!max_hit) begin
                  len_in = RUN_W'(1);
               end
            end
            if (max_hit || (len_in >= timeout_ticks)) begin
               active_in  = 1'b0;
               push_valid = 1'b1;
            end
         end
      end
   end

   assign push_data.bits  = bits_in;
   assign push_data.count = cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         prev_ff   <= 1'b1;
         len_ff    <= '0;
         idx_ff    <= '0;
         cnt_ff    <= '0;
         bits_ff   <= '0;
      end else begin
         active_ff <= active_in;
         prev_ff   <= prev_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         cnt_ff    <= cnt_in;
         bits_ff   <= bits_in;
      end
   end

endmodule

// File: rtl/dhtr_fifo.sv
module dhtr_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  dhtr_pkg::frame_type push_data,
   output logic                full,
   output logic                pop_valid,
   output dhtr_pkg::frame_type pop_data,
   input  logic                pop_ready
);
   import dhtr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   frame_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full      = (fill_ff == FILL_W'(DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~full;
   assign do_pop    = pop_valid & pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/dhtr_back.sv
module dhtr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  dhtr_pkg::frame_type pop_data,
   output logic                pop_ready,
   dhtr_rsp_if.source          rsp_bus
);
   import dhtr_pkg::*;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   byte_ff [4];
   logic [BYTE_W-1:0]   byte_in [4];
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                load;

   // output register takes a new frame when empty or being drained
   assign pop_ready = ~rsp_valid_ff | rsp_bus.ready;
   assign load      = pop_valid & pop_ready;

   // byte split: full bytes from the top of the left-aligned word,
   // the partial byte right-aligned, later bytes zero
   always_comb begin
      logic [FRAME_BITS-1:0] aligned;
      logic [2:0]            full_bytes;
      logic [2:0]            rem_bits;
      logic [BYTE_W-1:0]     partial;
      logic [BYTE_W-1:0]     sum;
      aligned    = pop_data.bits << (CNT_W'(FRAME_BITS) - pop_data.count);
      full_bytes = pop_data.count[CNT_W-1:3];
      rem_bits   = pop_data.count[2:0];
      partial    = pop_data.bits[BYTE_W-1:0] & ~({BYTE_W{1'b1}} << rem_bits);
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < full_bytes) begin
            byte_in[k] = aligned[FRAME_BITS-1-BYTE_W*k -: BYTE_W];
         end else if (3'(k) == full_bytes) begin
            byte_in[k] = partial;
         end else begin
            byte_in[k] = '0;
         end
      end
      // checksum only matters on a full frame, where bytes are the raw word
      sum = pop_data.bits[39:32] + pop_data.bits[31:24]
            + pop_data.bits[23:16] + pop_data.bits[15:8];
      if (pop_data.count < CNT_W'(FRAME_BITS)) begin
         status_in = STATUS_SHORT;
      end else if (sum == pop_data.bits[7:0]) begin
         status_in = STATUS_OK;
      end else begin
         status_in = STATUS_CHECKSUM;
      end
      rsp_valid_in = load | (rsp_valid_ff & ~rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         status_ff <= status_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.humidity_whole  = byte_ff[0];
   assign rsp_bus.humidity_tenths = byte_ff[1];
   assign rsp_bus.temp_whole      = byte_ff[2];
   assign rsp_bus.temp_tenths     = byte_ff[3];
   assign rsp_bus.frame_status    = status_ff;

endmodule

// File: rtl/dht11_pulse_width_receiver.sv
// Single-wire sensor receiver, pulse-width decoding.
// req_bus: one transaction per microsecond tick, carrying the sampled line
//   level; start_req set arms a fresh capture and clears all capture state.
// rsp_bus: one transaction per finished frame with the four data bytes and
//   a status (ok, checksum mismatch, fewer than forty bits).
// csr_bus: register writes, index 0 bit threshold, index 1 timeout; always
//   ready, to be written only while no capture is in flight.
// Throughput: one sample per cycle while req_bus.ready is high. A finished
//   frame is written into the queue, then byte split and checksummed into
//   the output register, which drives rsp_bus.valid.
// Stalls: finished frames wait in a QUEUE_DEPTH-entry queue behind the
//   output register; req_bus.ready drops only while that queue is full.
// Reset: threshold 16, timeout 255, capture inactive, queue and output empty.
module dht11_pulse_width_receiver #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   dhtr_req_if.sink   req_bus,
   dhtr_rsp_if.source rsp_bus,
   dhtr_csr_if.sink   csr_bus
);
   import dhtr_pkg::*;

   logic [RUN_W-1:0] bit_threshold_ff;
   logic [RUN_W-1:0] timeout_ticks_ff;
   logic             push_valid;
   frame_type        push_data;
   logic             queue_full;
   logic             pop_valid;
   frame_type        pop_data;
   logic             pop_ready;

   // configuration registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_threshold_ff <= BIT_THRESHOLD_RST;
         timeout_ticks_ff <= TIMEOUT_TICKS_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_BIT_THRESHOLD: bit_threshold_ff <= csr_bus.wr_data;
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_bus.wr_data;
            default: ;
         endcase
      end
   end

   dhtr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .bit_threshold (bit_threshold_ff),
      .timeout_ticks (timeout_ticks_ff),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_data     (push_data)
   );

   dhtr_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   dhtr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
